>>> rtl/ugs_pkg.sv
// Shared constants for the unique goal stack: defaults, request and status codes.
package ugs_pkg;

    localparam int DEF_STACK_DEPTH = 16;
    localparam int DEF_GOAL_BITS   = 16;

    localparam int STATUS_W = 3;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_PUSHED     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_POPPED     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_POP_EMPTY  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_PUSH_FULL  = 3'd4;

endpackage

>>> rtl/unique_goal_stack.sv
// Unique goal stack: LIFO of goal identifiers that refuses duplicate pushes.
//
// Each transaction on the slave side is one push (s_tuser = 0, goal in s_tdata) or one pop
// (s_tuser = 1) and yields exactly one result transaction on the master side. One request
// is taken every cycle while s_tready is high: the push goal is compared against all held
// entries in parallel and the stack pointer, entry file and result are updated in the same
// cycle, so the rate is one transaction per clock, set by that compare and update. Results
// pass through a two-entry output buffer, so a stalled master side blocks the slave side
// only once both entries are full. The result tdata holds the new top goal (zero when the
// stack is empty) and the fill count; tuser holds the status code and the top-valid flag.
module unique_goal_stack #(
    parameter int STACK_DEPTH = ugs_pkg::DEF_STACK_DEPTH,
    parameter int GOAL_BITS   = ugs_pkg::DEF_GOAL_BITS
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          s_tvalid,
    output logic                                          s_tready,
    // goal_id, zero padded to whole bytes
    input  logic [((GOAL_BITS+7)/8)*8-1:0]                s_tdata,
    // req_type
    input  logic                                          s_tuser,
    output logic                                          m_tvalid,
    input  logic                                          m_tready,
    // top_goal, fill_count, zero padded to whole bytes
    output logic [((GOAL_BITS+$clog2(STACK_DEPTH+1)+7)/8)*8-1:0] m_tdata,
    // status [2:0], top_valid [3]
    output logic [ugs_pkg::STATUS_W:0]                    m_tuser
);
    import ugs_pkg::*;

    localparam int CNT_W      = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int OUT_DATA_W = ((GOAL_BITS + CNT_W + 7) / 8) * 8;

    typedef struct packed {
        logic                 top_valid;
        logic [STATUS_W-1:0]  status;
        logic [CNT_W-1:0]     fill;
        logic [GOAL_BITS-1:0] top_goal;
    } rsp_t;

    logic [GOAL_BITS-1:0] entries_reg [STACK_DEPTH];
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;

    logic                 out_valid_reg;
    logic                 skid_valid_reg;
    rsp_t                 out_reg;
    rsp_t                 skid_reg;

    logic                 accept;
    logic                 take;
    logic [GOAL_BITS-1:0] goal;
    logic                 hit;
    logic                 full;
    logic                 do_push;
    logic [IDX_W-1:0]     top_pos;
    rsp_t                 rsp;

    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign take     = out_valid_reg && m_tready;
    assign goal     = s_tdata[GOAL_BITS-1:0];
    assign full     = (count_reg == CNT_W'(STACK_DEPTH));

    // Parallel duplicate check over the occupied entries
    always_comb
    begin
        hit = 1'b0;
        for (int i = 0; i < STACK_DEPTH; i++)
        begin
            if ((CNT_W'(i) < count_reg) && (entries_reg[i] == goal))
            begin
                hit = 1'b1;
            end
        end
    end

    always_comb
    begin
        do_push    = 1'b0;
        count_next = count_reg;
        rsp.status = ST_PUSHED;
        case (s_tuser)
            OP_PUSH:
            begin
                if (hit)
                begin
                    rsp.status = ST_DUPLICATE;
                end
                else if (full)
                begin
                    rsp.status = ST_PUSH_FULL;
                end
                else
                begin
                    do_push    = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                    rsp.status = ST_PUSHED;
                end
            end
            OP_POP:
            begin
                if (count_reg == '0)
                begin
                    rsp.status = ST_POP_EMPTY;
                end
                else
                begin
                    count_next = count_reg - CNT_W'(1);
                    rsp.status = ST_POPPED;
                end
            end
            default:
            begin
                rsp.status = ST_PUSHED;
            end
        endcase

        top_pos       = IDX_W'(count_next - CNT_W'(1));
        rsp.fill      = count_next;
        rsp.top_valid = (count_next != '0);
        if (do_push)
        begin
            rsp.top_goal = goal;
        end
        else if (count_next != '0)
        begin
            rsp.top_goal = entries_reg[top_pos];
        end
        else
        begin
            rsp.top_goal = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (accept)
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && do_push)
        begin
            entries_reg[count_reg[IDX_W-1:0]] <= goal;
        end
    end

    // Two-entry result buffer: the skid entry absorbs a transaction while the output stalls
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= accept;
            end
            else
            begin
                out_valid_reg <= accept;
            end
        end
        else if (accept)
        begin
            if (out_valid_reg)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            if (skid_valid_reg)
            begin
                out_reg <= skid_reg;
                if (accept)
                begin
                    skid_reg <= rsp;
                end
            end
            else if (accept)
            begin
                out_reg <= rsp;
            end
        end
        else if (accept)
        begin
            if (out_valid_reg)
            begin
                skid_reg <= rsp;
            end
            else
            begin
                out_reg <= rsp;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_DATA_W'({out_reg.fill, out_reg.top_goal});
    assign m_tuser  = {out_reg.top_valid, out_reg.status};

endmodule

>>> rtl/ugs_checker.sv
// Port-level assertions for the unique goal stack, bound to the top level.
module ugs_checker #(
    parameter int STACK_DEPTH = ugs_pkg::DEF_STACK_DEPTH,
    parameter int GOAL_BITS   = ugs_pkg::DEF_GOAL_BITS
) (
    input logic                                          clk,
    input logic                                          rst_n,
    input logic                                          m_tvalid,
    input logic                                          m_tready,
    // top_goal, fill_count
    input logic [((GOAL_BITS+$clog2(STACK_DEPTH+1)+7)/8)*8-1:0] m_tdata,
    // status [2:0], top_valid [3]
    input logic [ugs_pkg::STATUS_W:0]                    m_tuser
);
    import ugs_pkg::*;

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);

    logic [STATUS_W-1:0]  status;
    logic                 top_valid;
    logic [GOAL_BITS-1:0] top_goal;
    logic [CNT_W-1:0]     fill;

    assign status    = m_tuser[STATUS_W-1:0];
    assign top_valid = m_tuser[STATUS_W];
    assign top_goal  = m_tdata[GOAL_BITS-1:0];
    assign fill      = m_tdata[GOAL_BITS+CNT_W-1:GOAL_BITS];

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_top_matches_fill: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (top_valid == (fill != '0)))
        else $error("top_valid disagrees with fill count");

    a_empty_top_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !top_valid |-> (top_goal == '0))
        else $error("top goal nonzero on empty stack");

    a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (status == ST_POP_EMPTY) |-> (fill == '0))
        else $error("pop on empty reports entries");

    a_full_fill: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (status == ST_PUSH_FULL) |-> (fill == CNT_W'(STACK_DEPTH)))
        else $error("push on full with stack not full");

endmodule

bind unique_goal_stack ugs_checker #(
    .STACK_DEPTH (STACK_DEPTH),
    .GOAL_BITS   (GOAL_BITS)
) u_ugs_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
